// ===== sv/epfl_pkg.sv =====
package epfl_pkg;

  localparam int unsigned OP_W     = 3;
  localparam int unsigned SLOT_W   = 6;
  localparam int unsigned MASK_W   = 16;
  localparam int unsigned STATUS_W = 2;
  localparam int unsigned COUNT_W  = 7;
  localparam int unsigned LINK_W   = 7;

  localparam logic [LINK_W-1:0] LINK_NIL = 7'h7f;

  typedef enum logic [OP_W-1:0] {
    OP_ALLOC   = 3'd0,
    OP_RELEASE = 3'd1,
    OP_CLEAR   = 3'd2,
    OP_SET     = 3'd3,
    OP_CLR     = 3'd4,
    OP_QUERY   = 3'd5
  } epfl_op_e;

  typedef enum logic [STATUS_W-1:0] {
    STAT_OK   = 2'd0,
    STAT_FULL = 2'd1,
    STAT_DEAD = 2'd2
  } epfl_status_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DISPATCH,
    ST_ALLOC,
    ST_CHECK,
    ST_RELEASE,
    ST_WALK,
    ST_EMIT
  } epfl_state_e;

  typedef enum logic [3:0] {
    STEP_NONE,
    STEP_ALLOC_A,
    STEP_ALLOC_B,
    STEP_FULL,
    STEP_LOOKUP,
    STEP_DEAD,
    STEP_SET,
    STEP_CLR,
    STEP_UNLINK,
    STEP_REL_B,
    STEP_CLEAR,
    STEP_WALK_START,
    STEP_WALK
  } epfl_step_e;

  typedef struct packed {
    logic       latch;
    epfl_step_e step;
    logic       out_load;
    logic       out_pend;
  } epfl_cmd_t;

  typedef struct packed {
    epfl_op_e op;
    logic     free_ok;
    logic     slot_ok;
    logic     head_ok;
    logic     live;
    logic     match;
    logic     walk_done;
    logic     pend_valid;
    logic     out_free;
  } epfl_stat_t;

endpackage

// ===== sv/entity_pool_free_list_manager.sv =====
// channel | direction | handshake            | payload
// in      | input     | in_valid_i/in_ready_o | op_i, slot_index_i, component_mask_i
// out     | output    | out_valid_o/out_ready_i | status_o, result_slot_o, slot_valid_o,
//         |           |                      | last_result_o, live_count_o
// a query walks the active list slot by slot, reading each slot through the
// single read port of the link memories
// reset and clear restore the chains at once through per-entry valid bits
// a held result stalls only steps that load the output register
module entity_pool_free_list_manager
  import epfl_pkg::*;
#(
  parameter int unsigned POOL_SLOTS = 64,
  parameter int unsigned MASK_BITS  = 16
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  logic [OP_W-1:0]     op_i,
  input  logic [SLOT_W-1:0]   slot_index_i,
  input  logic [MASK_W-1:0]   component_mask_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output logic [STATUS_W-1:0] status_o,
  output logic [SLOT_W-1:0]   result_slot_o,
  output logic                slot_valid_o,
  output logic                last_result_o,
  output logic [COUNT_W-1:0]  live_count_o
);

  epfl_cmd_t  cmd;
  epfl_stat_t stat;

  epfl_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  epfl_dp #(
    .POOL_SLOTS (POOL_SLOTS),
    .MASK_BITS  (MASK_BITS)
  ) u_dp (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .op_i             (op_i),
    .slot_index_i     (slot_index_i),
    .component_mask_i (component_mask_i),
    .out_ready_i      (out_ready_i),
    .out_valid_o      (out_valid_o),
    .status_o         (status_o),
    .result_slot_o    (result_slot_o),
    .slot_valid_o     (slot_valid_o),
    .last_result_o    (last_result_o),
    .live_count_o     (live_count_o),
    .cmd_i            (cmd),
    .stat_o           (stat)
  );

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> !in_ready_o)
    else $error("second transaction taken while one is in flight");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (live_count_o <= COUNT_W'(POOL_SLOTS)))
    else $error("live count exceeds pool size");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && (status_o != STAT_OK)) |-> (!slot_valid_o && last_result_o))
    else $error("error result carries a slot or is not final");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !slot_valid_o) |-> (result_slot_o == '0))
    else $error("result slot set without slot valid");

endmodule

// ===== sv/epfl_ctrl.sv =====
module epfl_ctrl
  import epfl_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  epfl_stat_t stat_i,
  output epfl_cmd_t  cmd_o
);

  epfl_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) state_d = ST_DISPATCH;
      end
      ST_DISPATCH: begin
        case (stat_i.op) inside
          OP_ALLOC:                  state_d = stat_i.free_ok ? ST_ALLOC : ST_EMIT;
          OP_RELEASE, OP_SET, OP_CLR: state_d = stat_i.slot_ok ? ST_CHECK : ST_EMIT;
          OP_QUERY:                  state_d = stat_i.head_ok ? ST_WALK : ST_EMIT;
          default:                   state_d = ST_EMIT;
        endcase
      end
      ST_ALLOC: state_d = ST_EMIT;
      ST_CHECK: begin
        if (stat_i.live && stat_i.op == OP_RELEASE) state_d = ST_RELEASE;
        else state_d = ST_EMIT;
      end
      ST_RELEASE: state_d = ST_EMIT;
      ST_WALK: begin
        if (!(stat_i.match && stat_i.pend_valid && !stat_i.out_free) && stat_i.walk_done) begin
          state_d = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (stat_i.out_free) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready_o   = 1'b0;
    cmd_o        = '0;
    cmd_o.step   = STEP_NONE;
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o  = 1'b1;
        cmd_o.latch = in_valid_i;
      end
      ST_DISPATCH: begin
        case (stat_i.op) inside
          OP_ALLOC:                  cmd_o.step = stat_i.free_ok ? STEP_ALLOC_A : STEP_FULL;
          OP_RELEASE, OP_SET, OP_CLR: cmd_o.step = stat_i.slot_ok ? STEP_LOOKUP : STEP_DEAD;
          OP_CLEAR:                  cmd_o.step = STEP_CLEAR;
          OP_QUERY:                  cmd_o.step = stat_i.head_ok ? STEP_WALK_START : STEP_NONE;
          default:                   cmd_o.step = STEP_NONE;
        endcase
      end
      ST_ALLOC: cmd_o.step = STEP_ALLOC_B;
      ST_CHECK: begin
        if (!stat_i.live) begin
          cmd_o.step = STEP_DEAD;
        end else begin
          case (stat_i.op)
            OP_SET:     cmd_o.step = STEP_SET;
            OP_CLR:     cmd_o.step = STEP_CLR;
            OP_RELEASE: cmd_o.step = STEP_UNLINK;
            default:    cmd_o.step = STEP_NONE;
          endcase
        end
      end
      ST_RELEASE: cmd_o.step = STEP_REL_B;
      ST_WALK: begin
        if (!(stat_i.match && stat_i.pend_valid && !stat_i.out_free)) begin
          cmd_o.step     = STEP_WALK;
          cmd_o.out_load = stat_i.match && stat_i.pend_valid;
          cmd_o.out_pend = 1'b1;
        end
      end
      ST_EMIT: begin
        cmd_o.out_load = stat_i.out_free;
      end
      default: cmd_o.step = STEP_NONE;
    endcase
  end

endmodule

// ===== sv/epfl_dp.sv =====
module epfl_dp
  import epfl_pkg::*;
#(
  parameter int unsigned POOL_SLOTS = 64,
  parameter int unsigned MASK_BITS  = 16
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic [OP_W-1:0]     op_i,
  input  logic [SLOT_W-1:0]   slot_index_i,
  input  logic [MASK_W-1:0]   component_mask_i,
  input  logic                out_ready_i,
  output logic                out_valid_o,
  output logic [STATUS_W-1:0] status_o,
  output logic [SLOT_W-1:0]   result_slot_o,
  output logic                slot_valid_o,
  output logic                last_result_o,
  output logic [COUNT_W-1:0]  live_count_o,
  input  epfl_cmd_t           cmd_i,
  output epfl_stat_t          stat_o
);

  localparam int unsigned IDX_W = (POOL_SLOTS > 1) ? $clog2(POOL_SLOTS) : 1;
  localparam int unsigned MW    = (MASK_BITS < MASK_W) ? MASK_BITS : MASK_W;
  localparam logic [LINK_W-1:0] POOL_L = LINK_W'(POOL_SLOTS);
  localparam logic [IDX_W-1:0]  LAST_STEP = IDX_W'(POOL_SLOTS - 1);

  // latched transaction
  epfl_op_e          op_q;
  logic [SLOT_W-1:0] slot_q;
  logic [MW-1:0]     mask_q;

  // list heads and counters
  logic [LINK_W-1:0]  active_head_q, free_head_q;
  logic [COUNT_W-1:0] count_q;
  logic [IDX_W-1:0]   steps_q;
  logic [IDX_W-1:0]   pend_q;
  logic               pend_valid_q;

  // staged final result
  epfl_status_e      rs_status_q;
  logic [SLOT_W-1:0] rs_slot_q;
  logic              rs_valid_q;

  // output register
  logic              out_valid_q;
  epfl_status_e      out_status_q;
  logic [SLOT_W-1:0] out_slot_q;
  logic              out_svalid_q;
  logic              out_last_q;
  logic [COUNT_W-1:0] out_count_q;

  // memories
  logic [LINK_W-1:0] next_mem [POOL_SLOTS];
  logic [LINK_W-1:0] prev_mem [POOL_SLOTS];
  logic [MW:0]       info_mem [POOL_SLOTS];
  logic [POOL_SLOTS-1:0] next_vld_q, prev_vld_q, info_vld_q;

  logic              rd_en;
  logic [IDX_W-1:0]  rd_addr;
  logic [IDX_W-1:0]  rd_idx_q;
  logic [LINK_W-1:0] next_rd_q, prev_rd_q;
  logic [MW:0]       info_rd_q;
  logic              next_rd_vld_q, prev_rd_vld_q, info_rd_vld_q;

  logic              next_we, prev_we, info_we;
  logic [IDX_W-1:0]  next_wa, prev_wa, info_wa;
  logic [LINK_W-1:0] next_wd, prev_wd;
  logic [MW:0]       info_wd;

  logic [LINK_W-1:0] idx_link, idx_plus, next_eff, prev_eff;
  logic [MW:0]       info_eff;
  logic              live, match, walk_done, clear_all;

  assign idx_link = LINK_W'(rd_idx_q);
  assign idx_plus = idx_link + LINK_W'(1);
  assign next_eff = next_rd_vld_q ? next_rd_q : ((idx_plus < POOL_L) ? idx_plus : LINK_NIL);
  assign prev_eff = prev_rd_vld_q ? prev_rd_q
                  : ((rd_idx_q == '0) ? LINK_NIL : idx_link - LINK_W'(1));
  assign info_eff = info_rd_vld_q ? info_rd_q : '0;

  assign live      = info_eff[MW];
  assign match     = live && ((info_eff[MW-1:0] & mask_q) == mask_q);
  assign walk_done = !(next_eff < POOL_L) || (steps_q == LAST_STEP);
  assign clear_all = (cmd_i.step == STEP_CLEAR);

  always_comb begin
    stat_o.op         = op_q;
    stat_o.free_ok    = free_head_q < POOL_L;
    stat_o.slot_ok    = LINK_W'(slot_q) < POOL_L;
    stat_o.head_ok    = active_head_q < POOL_L;
    stat_o.live       = live;
    stat_o.match      = match;
    stat_o.walk_done  = walk_done;
    stat_o.pend_valid = pend_valid_q;
    stat_o.out_free   = !out_valid_q || out_ready_i;
  end

  // read port shared by all three memories
  always_comb begin
    rd_en   = 1'b0;
    rd_addr = '0;
    case (cmd_i.step)
      STEP_ALLOC_A: begin
        rd_en   = 1'b1;
        rd_addr = free_head_q[IDX_W-1:0];
      end
      STEP_LOOKUP: begin
        rd_en   = 1'b1;
        rd_addr = slot_q[IDX_W-1:0];
      end
      STEP_WALK_START: begin
        rd_en   = 1'b1;
        rd_addr = active_head_q[IDX_W-1:0];
      end
      STEP_WALK: begin
        rd_en   = !walk_done;
        rd_addr = next_eff[IDX_W-1:0];
      end
      default: rd_en = 1'b0;
    endcase
  end

  // write ports
  always_comb begin
    next_we = 1'b0;
    next_wa = '0;
    next_wd = '0;
    prev_we = 1'b0;
    prev_wa = '0;
    prev_wd = '0;
    info_we = 1'b0;
    info_wa = '0;
    info_wd = '0;
    case (cmd_i.step)
      STEP_ALLOC_A: begin
        prev_we = active_head_q < POOL_L;
        prev_wa = active_head_q[IDX_W-1:0];
        prev_wd = LINK_W'(free_head_q[IDX_W-1:0]);
      end
      STEP_ALLOC_B: begin
        next_we = 1'b1;
        next_wa = rd_idx_q;
        next_wd = active_head_q;
        prev_we = 1'b1;
        prev_wa = rd_idx_q;
        prev_wd = LINK_NIL;
        info_we = 1'b1;
        info_wa = rd_idx_q;
        info_wd = {1'b1, {MW{1'b0}}};
      end
      STEP_SET: begin
        info_we = 1'b1;
        info_wa = rd_idx_q;
        info_wd = {1'b1, info_eff[MW-1:0] | mask_q};
      end
      STEP_CLR: begin
        info_we = 1'b1;
        info_wa = rd_idx_q;
        info_wd = {1'b1, info_eff[MW-1:0] & ~mask_q};
      end
      STEP_UNLINK: begin
        next_we = prev_eff < POOL_L;
        next_wa = prev_eff[IDX_W-1:0];
        next_wd = next_eff;
        prev_we = next_eff < POOL_L;
        prev_wa = next_eff[IDX_W-1:0];
        prev_wd = prev_eff;
        info_we = 1'b1;
        info_wa = rd_idx_q;
        info_wd = {1'b0, info_eff[MW-1:0]};
      end
      STEP_REL_B: begin
        next_we = 1'b1;
        next_wa = rd_idx_q;
        next_wd = free_head_q;
        prev_we = 1'b1;
        prev_wa = rd_idx_q;
        prev_wd = LINK_NIL;
      end
      default: next_we = 1'b0;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (next_we) next_mem[next_wa] <= next_wd;
    if (prev_we) prev_mem[prev_wa] <= prev_wd;
    if (info_we) info_mem[info_wa] <= info_wd;
  end

  always_ff @(posedge clk_i) begin
    if (rd_en) begin
      next_rd_q     <= next_mem[rd_addr];
      prev_rd_q     <= prev_mem[rd_addr];
      info_rd_q     <= info_mem[rd_addr];
      next_rd_vld_q <= next_vld_q[rd_addr];
      prev_rd_vld_q <= prev_vld_q[rd_addr];
      info_rd_vld_q <= info_vld_q[rd_addr];
      rd_idx_q      <= rd_addr;
    end
  end

  // entries not written since reset or clear read as the reset chain
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      next_vld_q <= '0;
      prev_vld_q <= '0;
      info_vld_q <= '0;
    end else if (clear_all) begin
      next_vld_q <= '0;
      prev_vld_q <= '0;
      info_vld_q <= '0;
    end else begin
      if (next_we) next_vld_q[next_wa] <= 1'b1;
      if (prev_we) prev_vld_q[prev_wa] <= 1'b1;
      if (info_we) info_vld_q[info_wa] <= 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_head_q <= LINK_NIL;
      free_head_q   <= '0;
      count_q       <= '0;
      steps_q       <= '0;
      pend_valid_q  <= 1'b0;
    end else begin
      case (cmd_i.step)
        STEP_ALLOC_B: begin
          free_head_q   <= next_eff;
          active_head_q <= idx_link;
          count_q       <= count_q + COUNT_W'(1);
        end
        STEP_UNLINK: begin
          if (!(prev_eff < POOL_L)) active_head_q <= next_eff;
        end
        STEP_REL_B: begin
          free_head_q <= idx_link;
          count_q     <= count_q - COUNT_W'(1);
        end
        STEP_CLEAR: begin
          active_head_q <= LINK_NIL;
          free_head_q   <= '0;
          count_q       <= '0;
        end
        STEP_WALK_START: begin
          steps_q      <= '0;
          pend_valid_q <= 1'b0;
        end
        STEP_WALK: begin
          steps_q <= steps_q + IDX_W'(1);
          if (match) pend_valid_q <= 1'b1;
        end
        default: steps_q <= steps_q;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.latch) begin
      op_q        <= epfl_op_e'(op_i);
      slot_q      <= slot_index_i;
      mask_q      <= component_mask_i[MW-1:0];
      rs_status_q <= STAT_OK;
      rs_slot_q   <= '0;
      rs_valid_q  <= 1'b0;
    end else begin
      case (cmd_i.step)
        STEP_FULL: rs_status_q <= STAT_FULL;
        STEP_DEAD: rs_status_q <= STAT_DEAD;
        STEP_ALLOC_B: begin
          rs_slot_q  <= SLOT_W'(rd_idx_q);
          rs_valid_q <= 1'b1;
        end
        STEP_WALK: begin
          if (match) pend_q <= rd_idx_q;
          if (walk_done && match) begin
            rs_slot_q  <= SLOT_W'(rd_idx_q);
            rs_valid_q <= 1'b1;
          end else if (walk_done && pend_valid_q) begin
            rs_slot_q  <= SLOT_W'(pend_q);
            rs_valid_q <= 1'b1;
          end
        end
        default: rs_valid_q <= rs_valid_q;
      endcase
    end
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.out_load) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      out_count_q <= count_q;
      if (cmd_i.out_pend) begin
        out_status_q <= STAT_OK;
        out_slot_q   <= SLOT_W'(pend_q);
        out_svalid_q <= 1'b1;
        out_last_q   <= 1'b0;
      end else begin
        out_status_q <= rs_status_q;
        out_slot_q   <= rs_slot_q;
        out_svalid_q <= rs_valid_q;
        out_last_q   <= 1'b1;
      end
    end
  end

  assign out_valid_o   = out_valid_q;
  assign status_o      = out_status_q;
  assign result_slot_o = out_slot_q;
  assign slot_valid_o  = out_svalid_q;
  assign last_result_o = out_last_q;
  assign live_count_o  = out_count_q;

endmodule

// ===== tb/pool_list_checker.sv =====
`timescale 1ns / 1ps

module pool_list_checker
  import epfl_pkg::*;
#(
  parameter int unsigned POOL_SLOTS = 64,
  parameter int unsigned REPORT_CAP = 40
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  input  logic                in_ready_i,
  input  logic [OP_W-1:0]     op_i,
  input  logic [SLOT_W-1:0]   slot_index_i,
  input  logic [MASK_W-1:0]   component_mask_i,
  input  logic                out_valid_i,
  input  logic                out_ready_i,
  input  logic [STATUS_W-1:0] status_i,
  input  logic [SLOT_W-1:0]   result_slot_i,
  input  logic                slot_valid_i,
  input  logic                last_result_i,
  input  logic [COUNT_W-1:0]  live_count_i,
  output int unsigned         fail_count_o,
  output int unsigned         results_due_o,
  output int unsigned         ops_seen_o,
  output int unsigned         results_seen_o,
  output int unsigned         full_seen_o,
  output int unsigned         dead_seen_o,
  output int unsigned         most_hits_o
);

  localparam int unsigned PIDX_W = (POOL_SLOTS > 1) ? $clog2(POOL_SLOTS) : 1;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [SLOT_W-1:0]   slot;
    logic                valid;
    logic                last;
    logic [COUNT_W-1:0]  count;
  } slot_result_t;

  slot_result_t       results_due[$];
  slot_result_t       want;
  slot_result_t       got;
  logic [LINK_W-1:0]  next_of [POOL_SLOTS];
  logic [LINK_W-1:0]  prev_of [POOL_SLOTS];
  logic [MASK_W-1:0]  mask_of [POOL_SLOTS];
  logic               live_of [POOL_SLOTS];
  logic [LINK_W-1:0]  active_top;
  logic [LINK_W-1:0]  free_top;
  logic [COUNT_W-1:0] live_total;

  function automatic logic in_pool(logic [LINK_W-1:0] v);
    return v < LINK_W'(POOL_SLOTS);
  endfunction

  function automatic void due(epfl_status_e st, logic [LINK_W-1:0] slot, logic vld,
                              logic lst);
    slot_result_t r;
    r.status = st;
    r.slot   = vld ? slot[SLOT_W-1:0] : '0;
    r.valid  = vld;
    r.last   = lst;
    r.count  = live_total;
    results_due.push_back(r);
  endfunction

  function automatic void restore_chains();
    for (int i = 0; i < POOL_SLOTS; i++) begin
      next_of[i] = (i + 1 < POOL_SLOTS) ? LINK_W'(i + 1) : LINK_NIL;
      prev_of[i] = (i == 0) ? LINK_NIL : LINK_W'(i - 1);
      mask_of[i] = '0;
      live_of[i] = 1'b0;
    end
    active_top = LINK_NIL;
    free_top   = '0;
    live_total = '0;
  endfunction

  function automatic void advance_pool(logic [OP_W-1:0] op, logic [SLOT_W-1:0] s,
                                       logic [MASK_W-1:0] m);
    logic [LINK_W-1:0] f;
    logic [LINK_W-1:0] p;
    logic [LINK_W-1:0] n;
    logic [LINK_W-1:0] cur;
    logic [LINK_W-1:0] prior;
    logic [PIDX_W-1:0] fi;
    logic [PIDX_W-1:0] si;
    logic [PIDX_W-1:0] ci;
    logic              have;
    int unsigned       hits;
    int unsigned       steps;
    ops_seen_o++;
    case (op)
      OP_ALLOC: begin
        f = free_top;
        if (!in_pool(f)) begin
          full_seen_o++;
          due(STAT_FULL, '0, 1'b0, 1'b1);
        end else begin
          fi          = f[PIDX_W-1:0];
          free_top    = next_of[fi];
          mask_of[fi] = '0;
          live_of[fi] = 1'b1;
          next_of[fi] = active_top;
          prev_of[fi] = LINK_NIL;
          if (in_pool(active_top)) prev_of[active_top[PIDX_W-1:0]] = f;
          active_top = f;
          live_total = live_total + 1'b1;
          due(STAT_OK, f, 1'b1, 1'b1);
        end
      end
      OP_RELEASE, OP_SET, OP_CLR: begin
        if (!in_pool(LINK_W'(s)) || !live_of[s[PIDX_W-1:0]]) begin
          dead_seen_o++;
          due(STAT_DEAD, '0, 1'b0, 1'b1);
        end else begin
          si = s[PIDX_W-1:0];
          if (op == OP_SET) begin
            mask_of[si] = mask_of[si] | m;
          end else if (op == OP_CLR) begin
            mask_of[si] = mask_of[si] & ~m;
          end else begin
            p = prev_of[si];
            n = next_of[si];
            if (in_pool(p)) next_of[p[PIDX_W-1:0]] = n;
            else active_top = n;
            if (in_pool(n)) prev_of[n[PIDX_W-1:0]] = p;
            next_of[si] = free_top;
            prev_of[si] = LINK_NIL;
            free_top    = LINK_W'(s);
            live_of[si] = 1'b0;
            live_total  = live_total - 1'b1;
          end
          due(STAT_OK, '0, 1'b0, 1'b1);
        end
      end
      OP_CLEAR: begin
        restore_chains();
        due(STAT_OK, '0, 1'b0, 1'b1);
      end
      OP_QUERY: begin
        cur   = active_top;
        prior = '0;
        have  = 1'b0;
        hits  = 0;
        steps = 0;
        while (in_pool(cur) && steps < POOL_SLOTS) begin
          ci = cur[PIDX_W-1:0];
          if (live_of[ci] && (mask_of[ci] & m) == m) begin
            if (have) due(STAT_OK, prior, 1'b1, 1'b0);
            prior = cur;
            have  = 1'b1;
            hits++;
          end
          cur = next_of[ci];
          steps++;
        end
        if (have) due(STAT_OK, prior, 1'b1, 1'b1);
        else due(STAT_OK, '0, 1'b0, 1'b1);
        if (hits > most_hits_o) most_hits_o = hits;
      end
      default: due(STAT_OK, '0, 1'b0, 1'b1);
    endcase
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      restore_chains();
      results_due.delete();
      results_due_o = 0;
    end else begin
      if (out_valid_i && out_ready_i) begin
        results_seen_o++;
        got = '{status_i, result_slot_i, slot_valid_i, last_result_i, live_count_i};
        if (results_due.size() == 0) begin
          fail_count_o++;
          if (fail_count_o <= REPORT_CAP)
            $display({"%0t: result with nothing expected, ",
                      "got status %0d slot %0d valid %0b last %0b count %0d"},
                     $time, got.status, got.slot, got.valid, got.last, got.count);
        end else begin
          want = results_due.pop_front();
          if (got.status !== want.status || got.slot !== want.slot ||
              got.valid !== want.valid || got.last !== want.last ||
              got.count !== want.count) begin
            fail_count_o++;
            if (fail_count_o <= REPORT_CAP)
              $display({"%0t: mismatch, expected status %0d slot %0d valid %0b last %0b ",
                        "count %0d, got status %0d slot %0d valid %0b last %0b count %0d"},
                       $time, want.status, want.slot, want.valid, want.last, want.count,
                       got.status, got.slot, got.valid, got.last, got.count);
          end
        end
      end
      if (in_valid_i && in_ready_i) advance_pool(op_i, slot_index_i, component_mask_i);
      results_due_o = results_due.size();
    end
  end

endmodule

// ===== tb/tb_entity_pool_free_list_manager.sv =====
`timescale 1ns / 1ps

module tb_entity_pool_free_list_manager;
  import epfl_pkg::*;

  localparam int unsigned      SLOTS         = 64;
  localparam int unsigned      RANDOM_ITEMS  = 60;
  localparam int unsigned      SETTLE_CYCLES = 100;
  localparam logic [OP_W-1:0]  OP_SPARE_LO   = 3'd6;
  localparam logic [OP_W-1:0]  OP_SPARE_HI   = 3'd7;

  logic                clk_i            = 1'b0;
  logic                rst_ni           = 1'b0;
  logic                in_valid_i       = 1'b0;
  logic                in_ready_o;
  logic [OP_W-1:0]     op_i             = OP_ALLOC;
  logic [SLOT_W-1:0]   slot_index_i     = '0;
  logic [MASK_W-1:0]   component_mask_i = '0;
  logic                out_valid_o;
  logic                out_ready_i      = 1'b0;
  logic [STATUS_W-1:0] status_o;
  logic [SLOT_W-1:0]   result_slot_o;
  logic                slot_valid_o;
  logic                last_result_o;
  logic [COUNT_W-1:0]  live_count_o;

  int unsigned fail_count;
  int unsigned results_due;
  int unsigned ops_seen;
  int unsigned results_seen;
  int unsigned full_seen;
  int unsigned dead_seen;
  int unsigned most_hits;
  int unsigned send_idle_pct  = 0;
  int unsigned recv_stall_pct = 0;

  entity_pool_free_list_manager #(
    .POOL_SLOTS(SLOTS),
    .MASK_BITS (MASK_W)
  ) dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_ready_o      (in_ready_o),
    .op_i            (op_i),
    .slot_index_i    (slot_index_i),
    .component_mask_i(component_mask_i),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .status_o        (status_o),
    .result_slot_o   (result_slot_o),
    .slot_valid_o    (slot_valid_o),
    .last_result_o   (last_result_o),
    .live_count_o    (live_count_o)
  );

  pool_list_checker #(
    .POOL_SLOTS(SLOTS)
  ) checker_i (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_ready_i      (in_ready_o),
    .op_i            (op_i),
    .slot_index_i    (slot_index_i),
    .component_mask_i(component_mask_i),
    .out_valid_i     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .status_i        (status_o),
    .result_slot_i   (result_slot_o),
    .slot_valid_i    (slot_valid_o),
    .last_result_i   (last_result_o),
    .live_count_i    (live_count_o),
    .fail_count_o    (fail_count),
    .results_due_o   (results_due),
    .ops_seen_o      (ops_seen),
    .results_seen_o  (results_seen),
    .full_seen_o     (full_seen),
    .dead_seen_o     (dead_seen),
    .most_hits_o     (most_hits)
  );

  initial begin
    forever #10 clk_i = ~clk_i;
  end

  initial begin
    #20_000_000;
    $display("timeout with %0d results outstanding", results_due);
    $display("status: fail");
    $finish;
  end

  always @(negedge clk_i) begin
    out_ready_i <= ($urandom_range(99) >= recv_stall_pct);
  end

  task automatic send_item(input logic [OP_W-1:0] op, input logic [SLOT_W-1:0] slot,
                           input logic [MASK_W-1:0] mask);
    @(negedge clk_i);
    if ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      do @(negedge clk_i); while ($urandom_range(99) < send_idle_pct);
    end
    in_valid_i       <= 1'b1;
    op_i             <= op;
    slot_index_i     <= slot;
    component_mask_i <= mask;
    do @(posedge clk_i); while (!in_ready_o);
  endtask

  initial begin
    int unsigned      pick;
    logic [SLOT_W-1:0] slot;
    logic [MASK_W-1:0] mask;

    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // empty pool, dead slots and spare codes
    send_item(OP_QUERY, 6'd0, 16'h0000);
    send_item(OP_RELEASE, 6'd5, 16'h0000);
    send_item(OP_SET, 6'd0, 16'hffff);
    send_item(OP_CLR, 6'd0, 16'hffff);
    send_item(OP_SPARE_LO, 6'd0, 16'h0000);
    send_item(OP_SPARE_HI, 6'd63, 16'hffff);
    // three live slots with masks
    send_item(OP_ALLOC, 6'd0, 16'h0000);
    send_item(OP_ALLOC, 6'd0, 16'h0000);
    send_item(OP_ALLOC, 6'd0, 16'h0000);
    send_item(OP_SET, 6'd0, 16'hffff);
    send_item(OP_SET, 6'd1, 16'h00f0);
    send_item(OP_CLR, 6'd0, 16'h0f0f);
    send_item(OP_QUERY, 6'd0, 16'h0000);
    send_item(OP_QUERY, 6'd0, 16'hf0f0);
    send_item(OP_QUERY, 6'd0, 16'hffff);
    // unlink at head, middle and tail
    send_item(OP_RELEASE, 6'd2, 16'h0000);
    send_item(OP_QUERY, 6'd0, 16'h0000);
    send_item(OP_ALLOC, 6'd0, 16'h0000);
    send_item(OP_RELEASE, 6'd1, 16'h0000);
    send_item(OP_RELEASE, 6'd0, 16'h0000);
    send_item(OP_QUERY, 6'd0, 16'h0000);
    send_item(OP_RELEASE, 6'd2, 16'h0000);
    send_item(OP_RELEASE, 6'd63, 16'h0000);
    send_item(OP_CLEAR, 6'd0, 16'h0000);

    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin
          send_idle_pct  = 0;
          recv_stall_pct = 0;
        end
        1: begin
          send_idle_pct  = 77;
          recv_stall_pct = 0;
        end
        2: begin
          send_idle_pct  = 0;
          recv_stall_pct = 77;
        end
        default: begin
          send_idle_pct  = 13;
          recv_stall_pct = 13;
        end
      endcase

      if (phase == 0) begin
        // fill the pool past full, then walk it whole
        send_item(OP_CLEAR, 6'd0, 16'h0000);
        repeat (SLOTS + 2) send_item(OP_ALLOC, 6'($urandom_range(63)), 16'($urandom));
        send_item(OP_QUERY, 6'd0, 16'h0000);
        send_item(OP_SET, 6'd63, 16'h8001);
        send_item(OP_QUERY, 6'd0, 16'h8001);
      end

      repeat (RANDOM_ITEMS) begin
        pick = $urandom_range(99);
        slot = ($urandom_range(1) == 0) ? 6'($urandom_range(15)) : 6'($urandom_range(63));
        case ($urandom_range(3))
          0: mask = '0;
          1: mask = 16'(1) << $urandom_range(15);
          2: mask = 16'($urandom) & 16'($urandom) & 16'($urandom);
          default: mask = 16'($urandom);
        endcase
        if (pick < 35 || pick >= 96) send_item(OP_ALLOC, slot, 16'($urandom));
        else if (pick < 52) send_item(OP_RELEASE, slot, mask);
        else if (pick < 65) send_item(OP_SET, slot, 16'($urandom));
        else if (pick < 75) send_item(OP_CLR, slot, mask);
        else if (pick < 91) send_item(OP_QUERY, slot, mask);
        else if (pick < 93) send_item(OP_CLEAR, slot, mask);
        else send_item(($urandom_range(1) == 0) ? OP_SPARE_LO : OP_SPARE_HI, slot, mask);
      end
    end

    @(negedge clk_i);
    in_valid_i <= 1'b0;
    repeat (2) @(posedge clk_i);
    while (results_due != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);

    $display("%0d operations in, %0d results out, %0d pool-full and %0d dead-slot answers",
             ops_seen, results_seen, full_seen, dead_seen);
    $display("largest query answer %0d slots, run through sender and receiver idling mixes",
             most_hits);
    if (fail_count == 0 && results_due == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
